/* hdl/lca_binary_lifting_assert.svh */
// Assertion macros for the lowest-common-ancestor block.
// Used by the port checker; needs nothing else.
`ifndef LCA_BINARY_LIFTING_ASSERT_SVH
`define LCA_BINARY_LIFTING_ASSERT_SVH

// clocked check, off while reset is high
`define LCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked check, always on
`define LCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/lca_pkg.sv */
// Shared types, constants and helpers for the lowest-common-ancestor block.
// No dependencies.
`timescale 1ns / 1ps

package lca_pkg;

   localparam int NODE_COUNT  = 1024;
   localparam int JUMP_LEVELS = 11;
   localparam int LVL         = JUMP_LEVELS + 1;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int TIME_W      = 12;
   localparam int LVL_W       = $clog2(LVL);
   localparam int JADDR_W     = $clog2(NODE_COUNT * LVL);

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [TIME_W-1:0]  stamp_type;
   typedef logic [LVL_W-1:0]   lvl_type;
   typedef logic [JADDR_W-1:0] jaddr_type;

   localparam stamp_type CNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_ENTER = 2'd0,
      OP_LEAVE = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic      entered;
      logic      finished;
      stamp_type entry_time;
      stamp_type exit_time;
   } node_rec_type;

   localparam int REC_W = $bits(node_rec_type);

   typedef struct packed {
      logic         we;
      node_type     addr;
      node_rec_type wdata;
   } node_req_type;

   typedef struct packed {
      logic      we;
      jaddr_type addr;
      node_type  wdata;
   } jump_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_B,
      ST_DECIDE,
      ST_J_RD,
      ST_J_WR,
      ST_Q_NRD,
      ST_Q_CHK,
      ST_Q_OUT
   } state_type;

   // x is an ancestor of (or equal to) y by time interval
   function automatic logic covers(node_rec_type x, node_rec_type y);
      logic res;
      if (!x.entered || !y.entered) begin
         res = 1'b0;
      end else if (x.entry_time > y.entry_time) begin
         res = 1'b0;
      end else if (!x.finished) begin
         res = 1'b1;
      end else if (!y.finished) begin
         res = 1'b0;
      end else begin
         res = (x.exit_time >= y.exit_time);
      end
      return res;
   endfunction

   function automatic jaddr_type jump_addr(node_type n, lvl_type l);
      return jaddr_type'(n) * jaddr_type'(LVL) + jaddr_type'(l);
   endfunction

endpackage

/* hdl/lca_ram.sv */
// Generic single-port RAM, read-first, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lca_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/lca_ctrl.sv */
// Sequencer: stamps, jump-table fill, ancestor lifting, clear sweep.
// Depends on lca_pkg; drives the node and jump memories.
`timescale 1ns / 1ps

module lca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lca_pkg::op_type       req_op,
   input  lca_pkg::node_type     req_node,
   input  lca_pkg::node_type     req_other_node,
   output logic                  rsp_strobe,
   output lca_pkg::node_type     rsp_ancestor,
   output logic                  rsp_error,
   output lca_pkg::node_req_type node_req,
   input  lca_pkg::node_rec_type node_rdata,
   output lca_pkg::jump_req_type jump_req,
   input  lca_pkg::node_type     jump_rdata
);

   import lca_pkg::*;

   state_type    state_ff, state_in;
   op_type       op_ff, op_in;
   node_type     a_ff, a_in;
   node_type     b_ff, b_in;
   stamp_type    cnt_ff, cnt_in;
   node_rec_type rec_a_ff, rec_a_in;
   node_rec_type rec_b_ff, rec_b_in;
   node_type     mid_ff, mid_in;
   node_type     u_ff, u_in;
   node_type     w_ff, w_in;
   lvl_type      lvl_ff, lvl_in;
   node_type     clr_ff, clr_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   node_type     rsp_ancestor_ff, rsp_ancestor_in;
   logic         rsp_error_ff, rsp_error_in;

   logic     accept;
   logic     enter_ok;
   logic     leave_ok;
   logic     q_err;
   logic     cov_ab;
   logic     cov_ba;
   logic     cov_w;
   logic     q_done;
   node_type u_next;
   lvl_type  lvl_dec;

   assign accept   = start && (state_ff == ST_IDLE);
   assign enter_ok = !rec_a_ff.entered && (cnt_ff != CNT_MAX) &&
                     ((b_ff == a_ff) || node_rdata.entered);
   assign leave_ok = rec_a_ff.entered && !rec_a_ff.finished && (cnt_ff != CNT_MAX);
   assign q_err    = !rec_a_ff.finished || !node_rdata.finished;
   assign cov_ab   = covers(rec_a_ff, node_rdata);
   assign cov_ba   = covers(node_rdata, rec_a_ff);
   assign q_done   = q_err || cov_ab || cov_ba;
   assign cov_w    = covers(node_rdata, rec_b_ff);
   assign u_next   = cov_w ? u_ff : w_ff;
   assign lvl_dec  = (lvl_ff == '0) ? '0 : lvl_ff - lvl_type'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == node_type'(NODE_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = (req_op == OP_CLEAR) ? ST_CLEAR : ST_RD_B;
         end
         ST_RD_B: state_in = ST_DECIDE;
         ST_DECIDE: begin
            unique case (op_ff)
               OP_ENTER: state_in = enter_ok ? ST_J_RD : ST_IDLE;
               OP_QUERY: state_in = q_done ? ST_IDLE : ST_Q_NRD;
               OP_LEAVE,
               OP_CLEAR: state_in = ST_IDLE;
            endcase
         end
         ST_J_RD: state_in = ST_J_WR;
         ST_J_WR: state_in = (lvl_ff == lvl_type'(LVL - 1)) ? ST_IDLE : ST_J_RD;
         ST_Q_NRD: state_in = ST_Q_CHK;
         ST_Q_CHK: state_in = (lvl_ff == '0) ? ST_Q_OUT : ST_Q_NRD;
         ST_Q_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      cnt_in          = cnt_ff;
      rec_a_in        = rec_a_ff;
      rec_b_in        = rec_b_ff;
      mid_in          = mid_ff;
      u_in            = u_ff;
      w_in            = w_ff;
      lvl_in          = lvl_ff;
      clr_in          = clr_ff;
      rsp_strobe_in   = 1'b0;
      rsp_ancestor_in = rsp_ancestor_ff;
      rsp_error_in    = rsp_error_ff;
      node_req        = '0;
      node_req.addr   = a_ff;
      jump_req        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            node_req.we    = 1'b1;
            node_req.addr  = clr_ff;
            node_req.wdata = '0;
            clr_in         = clr_ff + node_type'(1);
         end
         ST_IDLE: begin
            node_req.addr = req_node;
            if (accept) begin
               op_in  = req_op;
               a_in   = req_node;
               b_in   = req_other_node;
               clr_in = '0;
               if (req_op == OP_CLEAR) cnt_in = '0;
            end
         end
         ST_RD_B: begin
            node_req.addr = b_ff;
            rec_a_in      = node_rdata;
         end
         ST_DECIDE: begin
            rec_b_in = node_rdata;
            unique case (op_ff)
               OP_ENTER: begin
                  if (enter_ok) begin
                     cnt_in                    = cnt_ff + stamp_type'(1);
                     node_req.we               = 1'b1;
                     node_req.addr             = a_ff;
                     node_req.wdata            = rec_a_ff;
                     node_req.wdata.entered    = 1'b1;
                     node_req.wdata.finished   = 1'b0;
                     node_req.wdata.entry_time = cnt_ff + stamp_type'(1);
                     jump_req.we               = 1'b1;
                     jump_req.addr             = jump_addr(a_ff, '0);
                     jump_req.wdata            = b_ff;
                     mid_in                    = b_ff;
                     lvl_in                    = lvl_type'(1);
                  end
               end
               OP_LEAVE: begin
                  if (leave_ok) begin
                     cnt_in                   = cnt_ff + stamp_type'(1);
                     node_req.we              = 1'b1;
                     node_req.addr            = a_ff;
                     node_req.wdata           = rec_a_ff;
                     node_req.wdata.finished  = 1'b1;
                     node_req.wdata.exit_time = cnt_ff + stamp_type'(1);
                  end
               end
               OP_QUERY: begin
                  priority if (q_err) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_ancestor_in = '0;
                     rsp_error_in    = 1'b1;
                  end else if (cov_ab) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_ancestor_in = a_ff;
                     rsp_error_in    = 1'b0;
                  end else if (cov_ba) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_ancestor_in = b_ff;
                     rsp_error_in    = 1'b0;
                  end else begin
                     jump_req.addr = jump_addr(a_ff, lvl_type'(LVL - 1));
                     u_in          = a_ff;
                     lvl_in        = lvl_type'(LVL - 1);
                  end
               end
               OP_CLEAR: begin
               end
            endcase
         end
         ST_J_RD: begin
            jump_req.addr = jump_addr(mid_ff, lvl_ff - lvl_type'(1));
         end
         ST_J_WR: begin
            jump_req.we    = 1'b1;
            jump_req.addr  = jump_addr(a_ff, lvl_ff);
            jump_req.wdata = jump_rdata;
            mid_in         = jump_rdata;
            lvl_in         = lvl_ff + lvl_type'(1);
         end
         ST_Q_NRD: begin
            node_req.addr = jump_rdata;
            w_in          = jump_rdata;
         end
         ST_Q_CHK: begin
            u_in          = u_next;
            jump_req.addr = jump_addr(u_next, lvl_dec);
            lvl_in        = lvl_dec;
         end
         ST_Q_OUT: begin
            rsp_strobe_in   = 1'b1;
            rsp_ancestor_in = jump_rdata;
            rsp_error_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      rec_a_ff        <= rec_a_in;
      rec_b_ff        <= rec_b_in;
      mid_ff          <= mid_in;
      u_ff            <= u_in;
      w_ff            <= w_in;
      lvl_ff          <= lvl_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
      rsp_error_ff    <= rsp_error_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_ancestor = rsp_ancestor_ff;
   assign rsp_error    = rsp_error_ff;

endmodule

/* hdl/lca_binary_lifting.sv */
// Lowest common ancestor by binary lifting: top level.
// Depends on lca_pkg, lca_ctrl and lca_ram.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. Ignored enters
// and all leaves pass ST_RD_B and ST_DECIDE only; an accepted enter then
// fills jump levels 1 to 11 with a read and a write each through the
// single-port jump memory. A query answers from ST_DECIDE on error or direct
// ancestry, else it lifts through each jump level: a jump read then a
// node-record read. Clear, and reset, sweep all 1024 node records with busy
// high. The result appears on rsp_* with a one-cycle rsp_strobe and cannot be held off.

module lca_binary_lifting (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lca_pkg::op_type   req_op,
   input  lca_pkg::node_type req_node,
   input  lca_pkg::node_type req_other_node,
   output logic              rsp_strobe,
   output lca_pkg::node_type rsp_ancestor,
   output logic              rsp_error
);

   import lca_pkg::*;

   node_req_type node_req;
   node_rec_type node_rdata;
   jump_req_type jump_req;
   node_type     jump_rdata;

   lca_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_node       (req_node),
      .req_other_node (req_other_node),
      .rsp_strobe     (rsp_strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_error      (rsp_error),
      .node_req       (node_req),
      .node_rdata     (node_rdata),
      .jump_req       (jump_req),
      .jump_rdata     (jump_rdata)
   );

   lca_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (REC_W)
   ) u_node_ram (
      .clock (clock),
      .we    (node_req.we),
      .addr  (node_req.addr),
      .wdata (node_req.wdata),
      .rdata (node_rdata)
   );

   lca_ram #(
      .DEPTH (NODE_COUNT * LVL),
      .WIDTH (NODE_W)
   ) u_jump_ram (
      .clock (clock),
      .we    (jump_req.we),
      .addr  (jump_req.addr),
      .wdata (jump_req.wdata),
      .rdata (jump_rdata)
   );

endmodule

/* hdl/lca_chk.sv */
// Port-level checker for lca_binary_lifting, bound to the top level.
// Depends on lca_pkg and lca_binary_lifting_assert.svh.
`timescale 1ns / 1ps
`include "lca_binary_lifting_assert.svh"

module lca_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [lca_pkg::NODE_W-1:0]    rsp_ancestor,
   input logic                          rsp_error
);

   `LCA_ASSERT(a_busy_after_take, clock, reset, (start && !busy) |=> busy, "no busy after take")
   `LCA_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe, "double strobe")
   `LCA_ASSERT(a_strobe_end, clock, reset, rsp_strobe |-> (!busy && $past(busy)), "stray strobe")
   `LCA_ASSERT(a_err_zero, clock, reset, (rsp_strobe && rsp_error) |-> (rsp_ancestor == '0), "error with ancestor")
   `LCA_ASSERT_ALWAYS(a_sweep_after_reset, clock, $fell(reset) |-> busy, "no sweep after reset")

endmodule

bind lca_binary_lifting lca_chk u_lca_chk (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_ancestor (rsp_ancestor),
   .rsp_error    (rsp_error)
);

/* sim/tb_lca_binary_lifting.sv */
// Testbench for lca_binary_lifting: depth-first event streams, queries and clears,
// checked against a behavioral tree predictor. Depends on lca_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_lca_binary_lifting;
   import lca_pkg::*;

   typedef struct packed {
      node_type ancestor;
      logic     error;
   } answer_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   op_type   req_op = OP_ENTER;
   node_type req_node = '0;
   node_type req_other_node = '0;
   logic     rsp_strobe;
   node_type rsp_ancestor;
   logic     rsp_error;

   lca_binary_lifting uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_node       (req_node),
      .req_other_node (req_other_node),
      .rsp_strobe     (rsp_strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_error      (rsp_error)
   );

   always #4 clock = ~clock;

   // tree predictor state
   bit [TIME_W-1:0] enter_stamp [NODE_COUNT];
   bit [TIME_W-1:0] leave_stamp [NODE_COUNT];
   bit              was_entered [NODE_COUNT];
   bit              was_left    [NODE_COUNT];
   bit [NODE_W-1:0] hop         [NODE_COUNT][LVL];
   bit [TIME_W-1:0] stamp_ctr;

   answer_type expected_answers [$];
   answer_type oldest_answer;

   // stimulus bookkeeping
   bit       taken [NODE_COUNT];
   int       taken_count;
   node_type open_path [$];
   node_type closed_nodes [$];

   int gap_pct;
   int mismatches;
   int txn_count;
   int answers_checked;
   int error_answers;
   int clear_count;
   int chain_depth;

   function automatic bit ancestor_of(input node_type x, input node_type y);
      if (!was_entered[x] || !was_entered[y]) return 1'b0;
      if (enter_stamp[x] > enter_stamp[y]) return 1'b0;
      if (!was_left[x]) return 1'b1;
      if (!was_left[y]) return 1'b0;
      return leave_stamp[x] >= leave_stamp[y];
   endfunction

   // applies one transaction to the predictor; returns 1 when it answers
   function automatic bit tree_step(input op_type op, input node_type a, input node_type b,
                                    output answer_type ans);
      node_type mid;
      node_type u;
      node_type w;
      ans = '{ancestor: '0, error: 1'b0};
      case (op)
         OP_ENTER: begin
            if (!was_entered[a] && stamp_ctr < CNT_MAX && (b == a || was_entered[b])) begin
               stamp_ctr++;
               enter_stamp[a] = stamp_ctr;
               was_entered[a] = 1'b1;
               hop[a][0] = b;
               for (int l = 1; l < LVL; l++) begin
                  mid = hop[a][l-1];
                  hop[a][l] = hop[mid][l-1];
               end
            end
            return 1'b0;
         end
         OP_LEAVE: begin
            if (was_entered[a] && !was_left[a] && stamp_ctr < CNT_MAX) begin
               stamp_ctr++;
               leave_stamp[a] = stamp_ctr;
               was_left[a] = 1'b1;
            end
            return 1'b0;
         end
         OP_CLEAR: begin
            foreach (was_entered[i]) begin
               was_entered[i] = 1'b0;
               was_left[i] = 1'b0;
            end
            stamp_ctr = '0;
            return 1'b0;
         end
         default: begin
            if (!was_left[a] || !was_left[b]) begin
               ans.error = 1'b1;
            end else if (ancestor_of(a, b)) begin
               ans.ancestor = a;
            end else if (ancestor_of(b, a)) begin
               ans.ancestor = b;
            end else begin
               u = a;
               for (int j = LVL - 1; j >= 0; j--) begin
                  w = hop[u][j];
                  if (!ancestor_of(w, b)) u = w;
               end
               ans.ancestor = hop[u][0];
            end
            return 1'b1;
         end
      endcase
   endfunction

   task automatic send_txn(input op_type op, input node_type a, input node_type b);
      answer_type ans;
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_node <= a;
      req_other_node <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      txn_count++;
      if (tree_step(op, a, b, ans)) expected_answers.push_back(ans);
   endtask

   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (expected_answers.size() != 0);
   endtask

   task automatic restart_forest();
      send_txn(OP_CLEAR, node_type'($urandom_range(0, NODE_COUNT - 1)),
               node_type'($urandom_range(0, NODE_COUNT - 1)));
      clear_count++;
      foreach (taken[i]) taken[i] = 1'b0;
      taken_count = 0;
      open_path.delete();
      closed_nodes.delete();
   endtask

   function automatic node_type fresh_node();
      node_type n;
      do n = node_type'($urandom_range(0, NODE_COUNT - 1)); while (taken[n]);
      return n;
   endfunction

   // mostly finished nodes, some open ones, a few arbitrary
   function automatic node_type pick_known();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8 && closed_nodes.size() != 0)
         return closed_nodes[$urandom_range(0, closed_nodes.size() - 1)];
      if (r < 9 && open_path.size() != 0)
         return open_path[$urandom_range(0, open_path.size() - 1)];
      return node_type'($urandom_range(0, NODE_COUNT - 1));
   endfunction

   task automatic open_node(input bit as_root);
      node_type n;
      node_type p;
      n = fresh_node();
      p = as_root ? n : open_path[$];
      taken[n] = 1'b1;
      taken_count++;
      send_txn(OP_ENTER, n, p);
      open_path.push_back(n);
   endtask

   task automatic close_top();
      node_type n;
      n = open_path.pop_back();
      send_txn(OP_LEAVE, n, node_type'($urandom_range(0, NODE_COUNT - 1)));
      closed_nodes.push_back(n);
   endtask

   task automatic random_query();
      send_txn(OP_QUERY, pick_known(), pick_known());
   endtask

   task automatic test_corner_cases();
      send_txn(OP_QUERY, 10'd0, 10'd1023);    // nothing entered yet
      send_txn(OP_ENTER, 10'd5, 10'd9);       // parent never entered
      send_txn(OP_ENTER, 10'd0, 10'd0);       // root
      send_txn(OP_ENTER, 10'd0, 10'd0);       // repeated enter
      send_txn(OP_QUERY, 10'd0, 10'd0);       // open node
      send_txn(OP_LEAVE, 10'd1023, 10'd0);    // stray leave
      send_txn(OP_ENTER, 10'd1023, 10'd0);
      send_txn(OP_ENTER, 10'd682, 10'd1023);
      send_txn(OP_LEAVE, 10'd682, 10'd1023);
      send_txn(OP_LEAVE, 10'd682, 10'd0);     // second leave
      send_txn(OP_ENTER, 10'd341, 10'd1023);
      send_txn(OP_LEAVE, 10'd341, 10'd682);
      send_txn(OP_QUERY, 10'd682, 10'd341);   // lift through open ancestors
      send_txn(OP_QUERY, 10'd341, 10'd682);
      send_txn(OP_QUERY, 10'd682, 10'd1023);  // one side still open
      send_txn(OP_LEAVE, 10'd1023, 10'd1023);
      send_txn(OP_QUERY, 10'd1023, 10'd682);  // direct ancestor
      send_txn(OP_QUERY, 10'd682, 10'd682);
      send_txn(OP_LEAVE, 10'd0, 10'd1023);
      send_txn(OP_QUERY, 10'd341, 10'd0);
      send_txn(OP_ENTER, 10'd7, 10'd7);       // second root
      send_txn(OP_LEAVE, 10'd7, 10'd0);
      send_txn(OP_QUERY, 10'd7, 10'd682);     // across trees
      send_txn(OP_CLEAR, 10'd1023, 10'd682);
      clear_count++;
      send_txn(OP_QUERY, 10'd0, 10'd341);     // flags gone after clear
      send_txn(OP_ENTER, 10'd12, 10'd0);      // parent gone after clear
   endtask

   task automatic test_dfs_walks(input int n_items);
      int r;
      restart_forest();
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         if (r < 2 || taken_count >= NODE_COUNT - 1) begin
            restart_forest();
         end else if (r < 6) begin
            send_txn(op_type'($urandom_range(0, 2)), node_type'($urandom_range(0, NODE_COUNT - 1)),
                     node_type'($urandom_range(0, NODE_COUNT - 1)));
         end else if (r < 26) begin
            random_query();
         end else if (open_path.size() == 0 || r < 66) begin
            open_node(open_path.size() == 0);
         end else begin
            close_top();
         end
      end
   endtask

   // one long open chain with short finished side branches
   task automatic test_deep_chain(input int depth);
      restart_forest();
      open_node(1'b1);
      for (int d = 1; d < depth; d++) begin
         open_node(1'b0);
         if ($urandom_range(0, 5) == 0) begin
            open_node(1'b0);
            close_top();
         end
      end
      chain_depth = depth;
      repeat (55) random_query();
   endtask

   task automatic test_random_noise(input int n_items);
      repeat (n_items) begin
         if ($urandom_range(0, 49) == 0) begin
            restart_forest();
         end else begin
            send_txn(op_type'($urandom_range(0, 2)), pick_known(),
                     $urandom_range(0, 1) ? pick_known() :
                                            node_type'($urandom_range(0, NODE_COUNT - 1)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            $error("rsp_strobe with no query outstanding");
            mismatches++;
         end else begin
            oldest_answer = expected_answers.pop_front();
            answers_checked++;
            if (oldest_answer.error) error_answers++;
            if (rsp_ancestor !== oldest_answer.ancestor) begin
               $error("ancestor: expected %0d, got %0d", oldest_answer.ancestor, rsp_ancestor);
               mismatches++;
            end
            if (rsp_error !== oldest_answer.error) begin
               $error("error: expected %0d, got %0d", oldest_answer.error, rsp_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct = 29;
      test_corner_cases();
      test_dfs_walks(220);
      wait_all_answered();
      gap_pct = 62;
      test_deep_chain(200);
      wait_all_answered();
      gap_pct = 0;
      test_dfs_walks(180);
      test_random_noise(60);
      wait_all_answered();
      repeat (64) @(posedge clock);
      $display("%0d transactions, %0d clears; %0d answers checked, %0d of them flagged",
               txn_count, clear_count, answers_checked, error_answers);
      $display("covered corner cases, random forests, an open chain of depth %0d and noise",
               chain_depth);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/lca_pkg.sv
hdl/lca_ram.sv
hdl/lca_ctrl.sv
hdl/lca_binary_lifting.sv
hdl/lca_chk.sv
sim/tb_lca_binary_lifting.sv
